[rtl/dq_pkg.sv]
package dq_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// input action codes
	typedef enum logic [2:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_LIST       = 3'd4
	} action_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// operation applied to every cell of the row in the same cycle
	typedef enum logic [2:0] {
		CELL_HOLD       = 3'd0,
		CELL_PUSH_FRONT = 3'd1,
		CELL_PUSH_BACK  = 3'd2,
		CELL_POP_FRONT  = 3'd3,
		CELL_POP_BACK   = 3'd4,
		CELL_ROTATE     = 3'd5
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [DATA_W-1:0]   value;
	} cell_ctrl_t;

endpackage

[rtl/double_ended_queue_core.sv]
// Double-ended queue of up to CAPACITY signed 32-bit values, held in a row of
// cells with the front value in the first cell. The action comes in on
// s_tuser, the value to push on s_tdata. A push or pop gives one result in the
// cycle after it is taken; back-to-back pushes and pops run at one item per
// cycle while the result side keeps up. A listing gives one result per value:
// the row rotates one cell per cycle while the result side keeps up and each
// rotation emits the head value, so after the last result the order is back
// as it was. An empty listing or pop, or a push into a full queue, gives one
// status-only result. Unused action codes are taken and give no result.
module double_ended_queue_core import dq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	input  logic [7:0]  s_tuser,  // [2:0] action, [7:3] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [31:0] value_res, [33:32] status, [39:34] zero
	output logic        m_tlast
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LIST = 2'b10
	} state_t;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CNT_W-1:0]  left_q, left_d;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	status_t           out_status_q;
	logic              out_last_q;

	logic              load;
	logic [DATA_W-1:0] res_value;
	status_t           res_status;
	logic              res_last;

	cell_ctrl_t        ctrl;
	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0] cell_valid;
	logic [CAPACITY-1:0] cell_tail;
	logic [DATA_W-1:0] tail_value;

	logic out_free, acc, full, empty;
	action_t action;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign acc      = s_tvalid && s_tready;
	assign action   = action_t'(s_tuser[2:0]);
	assign full     = cell_valid[CAPACITY-1];
	assign empty    = ~cell_valid[0];

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] pd, nd;
		logic              pv, nv;
		if (i == 0) begin : g_first
			assign pd = s_tdata;
			assign pv = 1'b1;
		end else begin : g_mid
			assign pd = cell_data[i-1];
			assign pv = cell_valid[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign nd = '0;
			assign nv = 1'b0;
		end else begin : g_inner
			assign nd = cell_data[i+1];
			assign nv = cell_valid[i+1];
		end
		dq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_data  (pd),
			.prev_valid (pv),
			.next_data  (nd),
			.next_valid (nv),
			.head_data  (cell_data[0]),
			.data       (cell_data[i]),
			.valid      (cell_valid[i]),
			.tail       (cell_tail[i])
		);
	end

	// select the back value: only the last occupied cell flags itself as tail
	always_comb begin
		tail_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tail_value = tail_value | (cell_data[i] & {DATA_W{cell_tail[i]}});
		end
	end

	// decode the action, drive the row and form the result
	always_comb begin
		ctrl.op    = CELL_HOLD;
		ctrl.value = s_tdata;
		load       = 1'b0;
		res_value  = '0;
		res_status = STAT_OK;
		res_last   = 1'b1;
		state_d    = state_q;
		cnt_d      = cnt_q;
		left_d     = left_q;
		if (acc) begin
			case (action)
				ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
					load = 1'b1;
					if (full) begin
						res_status = STAT_FULL;
					end else begin
						ctrl.op = (action == ACT_PUSH_FRONT) ? CELL_PUSH_FRONT : CELL_PUSH_BACK;
						cnt_d   = cnt_q + CNT_W'(1);
					end
				end
				ACT_POP_FRONT, ACT_POP_BACK: begin
					load = 1'b1;
					if (empty) begin
						res_status = STAT_EMPTY;
					end else if (action == ACT_POP_FRONT) begin
						ctrl.op   = CELL_POP_FRONT;
						res_value = cell_data[0];
						cnt_d     = cnt_q - CNT_W'(1);
					end else begin
						ctrl.op   = CELL_POP_BACK;
						res_value = tail_value;
						cnt_d     = cnt_q - CNT_W'(1);
					end
				end
				ACT_LIST: begin
					if (empty) begin
						load       = 1'b1;
						res_status = STAT_EMPTY;
					end else begin
						state_d = S_LIST;
						left_d  = cnt_q;
					end
				end
				default: ;
			endcase
		end else if (state_q == S_LIST && out_free) begin
			ctrl.op   = CELL_ROTATE;
			load      = 1'b1;
			res_value = cell_data[0];
			res_last  = (left_q == CNT_W'(1));
			left_d    = left_q - CNT_W'(1);
			if (res_last) state_d = S_IDLE;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			left_q  <= left_d;
			if (load)          out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// output register: hold until the transfer completes
	always_ff @(posedge clk) begin
		if (load) begin
			out_value_q  <= res_value;
			out_status_q <= res_status;
			out_last_q   <= res_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_status_q, out_value_q};
	assign m_tlast  = out_last_q;

endmodule

[rtl/dq_cell.sv]
module dq_cell import dq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic [DATA_W-1:0] prev_data,
	input  logic              prev_valid,
	input  logic [DATA_W-1:0] next_data,
	input  logic              next_valid,
	input  logic [DATA_W-1:0] head_data,
	output logic [DATA_W-1:0] data,
	output logic              valid,
	output logic              tail
);

	logic [DATA_W-1:0] data_q;
	logic              valid_q;

	// occupancy flag: shift, fill or drop with the neighbors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctrl.op)
				CELL_PUSH_FRONT: valid_q <= prev_valid;
				CELL_PUSH_BACK:  if (!valid_q && prev_valid) valid_q <= 1'b1;
				CELL_POP_FRONT:  valid_q <= next_valid;
				CELL_POP_BACK:   if (valid_q && !next_valid) valid_q <= 1'b0;
				default:         valid_q <= valid_q;
			endcase
		end
	end

	// payload: take from a neighbor, the pushed value or the head
	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_PUSH_FRONT: data_q <= prev_data;
			CELL_PUSH_BACK:  if (!valid_q && prev_valid) data_q <= ctrl.value;
			CELL_POP_FRONT:  data_q <= next_data;
			CELL_ROTATE:     if (valid_q) data_q <= next_valid ? next_data : head_data;
			default:         data_q <= data_q;
		endcase
	end

	assign data  = data_q;
	assign valid = valid_q;
	assign tail  = valid_q & ~next_valid;

endmodule

[rtl/dq_checker.sv]
module dq_checker import dq_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// a push or pop transfer gives its single result in the next cycle
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[2:0] == ACT_PUSH_FRONT ||
		s_tuser[2:0] == ACT_PUSH_BACK || s_tuser[2:0] == ACT_POP_FRONT ||
		s_tuser[2:0] == ACT_POP_BACK) |=> m_tvalid && m_tlast)
		else $error("push or pop result missing");

	// status-only results carry zero value and end their run
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33:32] != STAT_OK |-> m_tdata[31:0] == '0 && m_tlast)
		else $error("bad status-only result");

	// no undefined status code and zero padding
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[33:32] != 2'd3 && m_tdata[39:34] == '0)
		else $error("bad status code or padding");

endmodule

bind double_ended_queue_core dq_checker u_dq_checker (.*);

[sim/testbench.sv]
module testbench;
	import dq_pkg::*;

	localparam int LIMIT      = 500000;
	localparam int RAND_ITEMS = 230;
	localparam int SETTLE     = 2 * CAPACITY + 8;

	// one result as seen on the master side
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [1:0]        status;
		logic              last;
	} dq_result_t;

	// mirror of the deque contents and the results still owed by the block
	class deque_scoreboard;
		logic [DATA_W-1:0] ring [CAPACITY];
		int                head;
		int                fill;
		dq_result_t        owed[$];
		int                errors;

		function new();
			head   = 0;
			fill   = 0;
			errors = 0;
		endfunction

		function void owe(logic [DATA_W-1:0] v, status_t s, logic l);
			dq_result_t r;
			r.value  = v;
			r.status = s;
			r.last   = l;
			owed.push_back(r);
		endfunction

		// apply one accepted action and queue the results it causes
		function void note_item(logic [2:0] act, logic [DATA_W-1:0] v);
			int i;
			case (act)
				ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
					if (fill == CAPACITY) begin
						owe('0, STAT_FULL, 1'b1);
					end else begin
						if (act == ACT_PUSH_FRONT) begin
							head       = (head + CAPACITY - 1) % CAPACITY;
							ring[head] = v;
						end else begin
							ring[(head + fill) % CAPACITY] = v;
						end
						fill++;
						owe('0, STAT_OK, 1'b1);
					end
				end
				ACT_POP_FRONT: begin
					if (fill == 0) begin
						owe('0, STAT_EMPTY, 1'b1);
					end else begin
						owe(ring[head], STAT_OK, 1'b1);
						head = (head + 1) % CAPACITY;
						fill--;
					end
				end
				ACT_POP_BACK: begin
					if (fill == 0) begin
						owe('0, STAT_EMPTY, 1'b1);
					end else begin
						owe(ring[(head + fill - 1) % CAPACITY], STAT_OK, 1'b1);
						fill--;
					end
				end
				ACT_LIST: begin
					if (fill == 0) begin
						owe('0, STAT_EMPTY, 1'b1);
					end else begin
						for (i = 0; i < fill; i++)
							owe(ring[(head + i) % CAPACITY], STAT_OK, i == fill - 1);
					end
				end
				default: ;
			endcase
		endfunction

		// compare one transfer on the master side with the oldest owed result
		function void check_result(logic [DATA_W-1:0] v, logic [1:0] s, logic l);
			dq_result_t e;
			if (owed.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result value=%0d status=%0d last=%0b",
						$time, $signed(v), s, l);
				return;
			end
			e = owed.pop_front();
			if (v !== e.value || s !== e.status || l !== e.last) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch exp value=%0d status=%0d last=%0b, got value=%0d status=%0d last=%0b",
						$time, $signed(e.value), e.status, e.last, $signed(v), s, l);
			end
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic [7:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	deque_scoreboard sb = new();
	int              cycles  = 0;
	logic            no_idle = 1'b0;

	double_ended_queue_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// record every transfer on both sides
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_item(s_tuser[2:0], s_tdata);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata[31:0], m_tdata[33:32], m_tlast);
		end
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// throttle the result side
	initial begin
		int run;
		int stall;
		@(posedge arst_n);
		forever begin
			run = $urandom_range(1, 20);
			@(negedge clk) m_tready <= 1'b1;
			repeat (run - 1) @(negedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				@(negedge clk) m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
		end
	end

	// offer one item and hold it until the block takes it
	task automatic send_item(logic [2:0] act, logic [31:0] v);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= {5'b0, act};
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
	endtask

	// hold off the sender until every owed result has come out
	task automatic drain();
		@(negedge clk) s_tvalid <= 1'b0;
		while (sb.owed.size() != 0) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int          i;
		int          n;
		int          r;
		int          push_w;
		int          mode;
		logic [2:0]  act;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// empty-queue cases
		send_item(ACT_LIST, 32'h1234_5678);
		send_item(ACT_POP_FRONT, 32'hFFFF_FFFF);
		send_item(ACT_POP_BACK, 32'h0);
		// push at back into an empty queue, then extremes at both ends
		send_item(ACT_PUSH_BACK, 32'h8000_0000);
		send_item(ACT_PUSH_FRONT, 32'h7FFF_FFFF);
		send_item(ACT_PUSH_BACK, 32'hFFFF_FFFF);
		send_item(ACT_LIST, 32'h0);
		// unused codes are swallowed
		send_item(3'd5, 32'hFFFF_FFFF);
		send_item(3'd6, 32'h0);
		send_item(3'd7, 32'hA5A5_A5A5);
		// fill up, overflow at both ends, list a full queue
		for (i = 0; i < CAPACITY - 3; i++)
			send_item(i[0] ? ACT_PUSH_FRONT : ACT_PUSH_BACK, $urandom);
		send_item(ACT_PUSH_FRONT, 32'h0);
		send_item(ACT_PUSH_BACK, 32'hFFFF_FFFF);
		send_item(ACT_LIST, 32'h0);

		// random runs, biased toward filling or draining in turns
		n    = 0;
		mode = 1;
		while (n < RAND_ITEMS) begin
			if (n % 20 == 0)
				mode = $urandom_range(0, 2);
			if (n == 100)
				drain();
			no_idle = (n >= 150 && n < 190);
			push_w  = (mode == 0) ? 60 : (mode == 1) ? 20 : 43;
			r = $urandom_range(0, 99);
			if (r < 10)
				act = ACT_LIST;
			else if (r < 13)
				act = 3'($urandom_range(5, 7));
			else if (r < 13 + push_w)
				act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
			else
				act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
			send_item(act, pick_value());
			if (act <= ACT_LIST)
				n++;
		end
		no_idle = 1'b0;

		@(negedge clk) s_tvalid <= 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		sb.errors += sb.owed.size();
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
